@@ rtl/filter_weight_binarizer_core_macros.svh @@
// Assertion macros for the filter weight binarizer core.
// Depends on nothing; expects clk and arst_n in the scope of each use.
`ifndef FILTER_WEIGHT_BINARIZER_CORE_MACROS_SVH
`define FILTER_WEIGHT_BINARIZER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define FWB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FWB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FWB_ASSERT_SAME(label, ante, cons, msg)
`define FWB_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ rtl/fwb_pkg.sv @@
// Shared types for the filter weight binarizer core.
// Holds the sequencer state encoding; depends on nothing.
package fwb_pkg;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_RESP = 3'b100
	} fwb_state_t;

	// Flags captured when a read word is accepted.
	typedef struct packed {
		logic empty;
		logic eof;
	} fwb_rd_flags_t;

endpackage

@@ rtl/filter_weight_binarizer_core.sv @@
// Filter weight binarizer core: the marked last load keeps busy high while a
// restoring divider forms the mean, one quotient bit per cycle. A read word gives its
// result on the strobe in the cycle after acceptance (one registered store read); busy
// stays high while that result is presented, so a new word is taken only after it.
// Reset (arst_n low, asynchronous) empties the filter; the weight store is not cleared.
// The receiver cannot stall: each result is presented for exactly one cycle.
`include "filter_weight_binarizer_core_macros.svh"

module filter_weight_binarizer_core #(
	parameter int MAX_FILTER_LEN = 4096,
	parameter int WEIGHT_BITS    = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic signed [WEIGHT_BITS-1:0] weight,
	input  logic                          last_weight,
	output logic                          done,
	output logic signed [WEIGHT_BITS-1:0] value,
	output logic                          end_of_filter,
	output logic                          empty_res
);

	localparam int CNT_W  = $clog2(MAX_FILTER_LEN + 1);
	localparam int IDX_W  = (MAX_FILTER_LEN > 1) ? $clog2(MAX_FILTER_LEN) : 1;
	localparam int SUM_W  = CNT_W + WEIGHT_BITS - 1;
	localparam int MEAN_W = WEIGHT_BITS - 1;
	localparam int DCW    = $clog2(SUM_W + 1);

	fwb_pkg::fwb_state_t    state_q;
	fwb_pkg::fwb_rd_flags_t flags_q;

	logic [WEIGHT_BITS-1:0] mem [MAX_FILTER_LEN];
	logic [WEIGHT_BITS-1:0] rd_data_q;

	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  read_idx_q;
	logic [MEAN_W-1:0] mean_q;
	logic              ready_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DCW-1:0]    div_cnt_q;

	logic                   accept;
	logic                   load_acc;
	logic                   read_acc;
	logic [WEIGHT_BITS-1:0] abs_w;
	logic [SUM_W-1:0]       base_sum;
	logic [CNT_W-1:0]       base_cnt;
	logic                   room;
	logic [SUM_W-1:0]       sum_nxt;
	logic [CNT_W-1:0]       cnt_nxt;
	logic                   we;

	logic [CNT_W:0]      shifted;
	logic [CNT_W:0]      diff;
	logic                ge;
	logic [CNT_W-1:0]    rem_nxt;
	logic [SUM_W-1:0]    quo_nxt;
	logic [MEAN_W-1:0]   mean_sat;

	logic                   rd_pos;
	logic [WEIGHT_BITS-1:0] mean_ext;

	assign busy     = (state_q != fwb_pkg::ST_IDLE);
	assign accept   = start && !busy;
	assign load_acc = accept && !operation;
	assign read_acc = accept && operation;

	// A load into a finished filter throws the old one away and starts afresh.
	assign abs_w    = weight[WEIGHT_BITS-1] ? (~weight + WEIGHT_BITS'(1)) : weight;
	assign base_sum = ready_q ? '0 : sum_q;
	assign base_cnt = ready_q ? '0 : count_q;
	assign room     = (base_cnt < CNT_W'(MAX_FILTER_LEN));
	assign sum_nxt  = room ? (base_sum + SUM_W'(abs_w)) : base_sum;
	assign cnt_nxt  = room ? (base_cnt + CNT_W'(1)) : base_cnt;
	assign we       = load_acc && room;

	// One restoring division step per cycle.
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign diff    = shifted - {1'b0, count_q};
	assign ge      = (shifted >= {1'b0, count_q});
	assign rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
	assign quo_nxt = {quo_q[SUM_W-2:0], ge};
	assign mean_sat = (|quo_nxt[SUM_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : quo_nxt[MEAN_W-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[base_cnt[IDX_W-1:0]] <= weight;
		end
		if (read_acc) begin
			rd_data_q <= mem[read_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fwb_pkg::ST_IDLE;
			flags_q    <= '0;
			sum_q      <= '0;
			count_q    <= '0;
			read_idx_q <= '0;
			mean_q     <= '0;
			ready_q    <= 1'b0;
			quo_q      <= '0;
			rem_q      <= '0;
			div_cnt_q  <= '0;
		end else begin
			case (state_q)
				fwb_pkg::ST_IDLE: begin
					if (load_acc) begin
						sum_q      <= sum_nxt;
						count_q    <= cnt_nxt;
						ready_q    <= 1'b0;
						read_idx_q <= '0;
						if (last_weight) begin
							quo_q     <= sum_nxt;
							rem_q     <= '0;
							div_cnt_q <= DCW'(SUM_W);
							state_q   <= fwb_pkg::ST_DIV;
						end
					end else if (read_acc) begin
						flags_q.empty <= !ready_q;
						flags_q.eof   <= ready_q &&
							((CNT_W'(read_idx_q) + CNT_W'(1)) == count_q);
						state_q       <= fwb_pkg::ST_RESP;
					end
				end
				fwb_pkg::ST_DIV: begin
					quo_q     <= quo_nxt;
					rem_q     <= rem_nxt;
					div_cnt_q <= div_cnt_q - DCW'(1);
					if (div_cnt_q == DCW'(1)) begin
						mean_q  <= mean_sat;
						ready_q <= 1'b1;
						state_q <= fwb_pkg::ST_IDLE;
					end
				end
				fwb_pkg::ST_RESP: begin
					if (!flags_q.empty) begin
						if (flags_q.eof) begin
							ready_q    <= 1'b0;
							count_q    <= '0;
							sum_q      <= '0;
							read_idx_q <= '0;
						end else begin
							read_idx_q <= read_idx_q + IDX_W'(1);
						end
					end
					state_q <= fwb_pkg::ST_IDLE;
				end
				default: begin
					state_q <= fwb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// A stored weight of zero counts as not positive and gives the negated mean.
	assign rd_pos   = !rd_data_q[WEIGHT_BITS-1] && (|rd_data_q);
	assign mean_ext = {1'b0, mean_q};

	assign done          = (state_q == fwb_pkg::ST_RESP);
	assign empty_res     = done && flags_q.empty;
	assign end_of_filter = done && !flags_q.empty && flags_q.eof;
	assign value         = (!done || flags_q.empty) ? '0 :
		(rd_pos ? mean_ext : ('0 - mean_ext));

	`FWB_ASSERT_NEXT(a_read_gives_word, read_acc, done, "read word produced no result")
	`FWB_ASSERT_NEXT(a_load_no_word, load_acc, !done, "load word produced a result")
	`FWB_ASSERT_SAME(a_div_nonzero, state_q == fwb_pkg::ST_DIV, count_q != '0, "divide by zero")
	`FWB_ASSERT_NEXT(a_eof_clears, done && end_of_filter, !ready_q, "filter kept after last read")

endmodule
